// File: hdl/arp_address_cache_assert.svh
// Assertion macros for the ARP address cache.
// Used by the top level only; no dependencies.
`ifndef ARP_ADDRESS_CACHE_ASSERT_SVH
`define ARP_ADDRESS_CACHE_ASSERT_SVH

`ifndef SYNTHESIS
`define ARPC_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("arp cache: same-cycle check failed");
`define ARPC_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("arp cache: next-cycle check failed");
`else
`define ARPC_ASSERT_SAME(label, clk, rst, a, b)
`define ARPC_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// File: hdl/arpc_pkg.sv
// Shared types for the ARP address cache: the command and status
// groups passed between controller and datapath. No dependencies.
package arpc_pkg;

   typedef enum logic [1:0] {
      STORE_NONE,
      STORE_UPDATE,
      STORE_APPEND,
      STORE_EVICT
   } arpc_store_type;

   typedef struct packed {
      logic           capture;
      logic           compare;
      logic           encode;
      logic           fetch;
      arpc_store_type store;
      logic           respond;
      logic           resp_mac;
   } arpc_cmd_type;

   typedef struct packed {
      logic insert;
      logic hit;
      logic full;
   } arpc_stat_type;

endpackage

// File: hdl/arp_address_cache.sv
// Top level of the ARP address cache: a fully associative IPv4 to MAC table
// with round-robin replacement. Depends on arpc_pkg, arpc_controller,
// arpc_datapath and arp_address_cache_assert.svh.
//
//   Channel    Handshake            Payload
//   request    start, busy          req_mode, req_ip_key, req_mac_value
//   response   rsp_strobe           rsp_found, rsp_mac_result, rsp_evicted
//
// A request is taken when start is high and busy is low. Its response strobe
// follows the registered match vector and the registered index encoder, and
// for a lookup that hits also the registered read of the MAC memory. A new
// request is taken on the edge that ends the response cycle.
// Reset empties the table at once; no clearing pass is needed.
`include "arp_address_cache_assert.svh"

module arp_address_cache #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [31:0] req_ip_key,
   input  logic [47:0] req_mac_value,
   output logic        rsp_strobe,
   output logic        rsp_found,
   output logic [47:0] rsp_mac_result,
   output logic        rsp_evicted
);

   arpc_pkg::arpc_cmd_type  cmd;
   arpc_pkg::arpc_stat_type status;

   arpc_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   arpc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_ip_key     (req_ip_key),
      .req_mac_value  (req_mac_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_mac_result (rsp_mac_result),
      .rsp_evicted    (rsp_evicted)
   );

   `ARPC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ARPC_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe)
   `ARPC_ASSERT_SAME(a_evict_not_found, clock, reset, rsp_strobe && rsp_evicted, !rsp_found)
   `ARPC_ASSERT_SAME(a_evict_no_mac, clock, reset, rsp_strobe && rsp_evicted, rsp_mac_result == 48'd0)

endmodule

// File: hdl/arpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module arpc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/arpc_datapath.sv
// Datapath of the ARP address cache: request registers, IP match array,
// fill and victim counters, MAC memory and result registers.
// Depends on arpc_pkg and arpc_ram.
module arpc_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_mode,
   input  logic [31:0]            req_ip_key,
   input  logic [47:0]            req_mac_value,
   input  arpc_pkg::arpc_cmd_type cmd,
   output arpc_pkg::arpc_stat_type status,
   output logic                   rsp_strobe,
   output logic                   rsp_found,
   output logic [47:0]            rsp_mac_result,
   output logic                   rsp_evicted
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int FILL_W = $clog2(ENTRIES + 1);

   logic               mode_ff;
   logic [31:0]        key_ff;
   logic [47:0]        mac_ff;
   logic [31:0]        ip_ff [ENTRIES];
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] match_in;
   logic               hit_ff;
   logic               hit_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic [IDX_W-1:0]   victim_ff;
   logic [IDX_W-1:0]   victim_in;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [47:0]        ram_rd_data;
   logic               rsp_strobe_ff;
   logic               rsp_found_ff;
   logic [47:0]        rsp_mac_ff;
   logic               rsp_evicted_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         key_ff  <= req_ip_key;
         mac_ff  <= req_mac_value;
      end
   end

   // Only slots below the fill count hold written entries.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = (ip_ff[i] == key_ff) && (FILL_W'(i) < fill_ff);
      end
   end

   // At most one slot matches, so OR-ing the indexes of set bits encodes it.
   always_comb begin
      idx_in = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_ff[i]) begin
            idx_in = idx_in | IDX_W'(i);
         end
      end
      hit_in = |match_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_in;
      end
      if (cmd.encode) begin
         hit_ff <= hit_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = idx_ff;
      fill_in   = fill_ff;
      victim_in = victim_ff;
      case (cmd.store)
         arpc_pkg::STORE_UPDATE: begin
            wr_en  = 1'b1;
            wr_idx = idx_ff;
         end
         arpc_pkg::STORE_APPEND: begin
            wr_en   = 1'b1;
            wr_idx  = fill_ff[IDX_W-1:0];
            fill_in = fill_ff + FILL_W'(1);
         end
         arpc_pkg::STORE_EVICT: begin
            wr_en     = 1'b1;
            wr_idx    = victim_ff;
            victim_in = (victim_ff == IDX_W'(ENTRIES - 1)) ? '0 : victim_ff + IDX_W'(1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // An update rewrites the same key, so the IP array is written on any store.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ip_ff[wr_idx] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         victim_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         victim_ff <= victim_in;
      end
   end

   arpc_ram #(
      .WIDTH (48),
      .DEPTH (ENTRIES)
   ) u_mac_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (mac_ff),
      .rd_en   (cmd.fetch),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_found_ff   <= hit_ff;
         rsp_mac_ff     <= cmd.resp_mac ? ram_rd_data : '0;
         rsp_evicted_ff <= (cmd.store == arpc_pkg::STORE_EVICT);
      end
   end

   assign status.insert  = mode_ff;
   assign status.hit     = hit_ff;
   assign status.full    = (fill_ff == FILL_W'(ENTRIES));

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_mac_result = rsp_mac_ff;
   assign rsp_evicted    = rsp_evicted_ff;

endmodule

// File: hdl/arpc_controller.sv
// Controller of the ARP address cache: sequences compare, encode, store
// or fetch, and response for one request at a time. Depends on arpc_pkg.
module arpc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  arpc_pkg::arpc_stat_type status,
   output arpc_pkg::arpc_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_ENCODE,
      ST_ACT,
      ST_FETCH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.store    = arpc_pkg::STORE_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_ENCODE;
         end
         ST_ENCODE: begin
            cmd.encode = 1'b1;
            state_in   = ST_ACT;
         end
         ST_ACT: begin
            if (!status.insert && status.hit) begin
               cmd.fetch = 1'b1;
               state_in  = ST_FETCH;
            end else begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
               if (status.insert) begin
                  if (status.hit) begin
                     cmd.store = arpc_pkg::STORE_UPDATE;
                  end else if (status.full) begin
                     cmd.store = arpc_pkg::STORE_EVICT;
                  end else begin
                     cmd.store = arpc_pkg::STORE_APPEND;
                  end
               end
            end
         end
         ST_FETCH: begin
            cmd.respond  = 1'b1;
            cmd.resp_mac = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// File: tb/tb_arp_address_cache.sv
// Self-checking testbench for arp_address_cache: lookups and inserts are driven
// through the start/busy port and every response is checked against a model.
// Depends only on the RTL of the cache.
`timescale 1ns / 1ps

module tb_arp_address_cache;

   localparam int CACHE_SLOTS = 16;
   localparam int IDLE_PERCENT = 13;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASES = 7;
   localparam int PHASE_REQUESTS = 250;
   localparam int QUIET_FIRST = 700;
   localparam int QUIET_LAST = 1000;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef struct {
      logic        mode;
      logic [31:0] ip;
      logic [47:0] mac;
      bit          drain;
   } arp_request_type;

   typedef struct packed {
      logic        found;
      logic [47:0] mac;
      logic        evicted;
   } arp_reply_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = MODE_LOOKUP;
   logic [31:0] req_ip_key = '0;
   logic [47:0] req_mac_value = '0;
   logic        rsp_strobe;
   logic        rsp_found;
   logic [47:0] rsp_mac_result;
   logic        rsp_evicted;

   arp_request_type request_queue[$];
   arp_reply_type   pending_replies[$];

   // Model of the table contents.
   logic [31:0] ip_slots[CACHE_SLOTS];
   logic [47:0] mac_slots[CACHE_SLOTS];
   int          slots_used = 0;
   int          oldest_slot = 0;

   bit req_taken = 1'b0;
   int accepted_count = 0;
   int error_count = 0;
   int idle_cycles = 0;

   arp_address_cache #(
      .ENTRIES(CACHE_SLOTS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_ip_key    (req_ip_key),
      .req_mac_value (req_mac_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_found     (rsp_found),
      .rsp_mac_result(rsp_mac_result),
      .rsp_evicted   (rsp_evicted)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one request to the model table and returns the response it gives.
   function automatic arp_reply_type arp_cache_access(input logic mode, input logic [31:0] ip,
                                                      input logic [47:0] mac);
      arp_reply_type reply;
      int hit_slot;
      reply = '0;
      hit_slot = -1;
      for (int i = 0; i < slots_used; i++) begin
         if (hit_slot < 0 && ip_slots[i] == ip) begin
            hit_slot = i;
         end
      end
      if (mode == MODE_LOOKUP) begin
         if (hit_slot >= 0) begin
            reply.found = 1'b1;
            reply.mac = mac_slots[hit_slot];
         end
      end else if (hit_slot >= 0) begin
         // An update keeps the slot's age, so the victim pointer stays put.
         reply.found = 1'b1;
         mac_slots[hit_slot] = mac;
      end else if (slots_used < CACHE_SLOTS) begin
         ip_slots[slots_used] = ip;
         mac_slots[slots_used] = mac;
         slots_used++;
      end else begin
         ip_slots[oldest_slot] = ip;
         mac_slots[oldest_slot] = mac;
         oldest_slot = (oldest_slot == CACHE_SLOTS - 1) ? 0 : oldest_slot + 1;
         reply.evicted = 1'b1;
      end
      return reply;
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic add_request(input logic mode, input logic [31:0] ip,
                              input logic [47:0] mac, input bit drain);
      arp_request_type req;
      req.mode = mode;
      req.ip = ip;
      req.mac = mac;
      req.drain = drain;
      request_queue.push_back(req);
   endtask

   // Sender: changes the request on the falling edge.
   always @(negedge clock) begin : drive_requests
      arp_request_type next_req;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (request_queue.size() == 0 ||
             (request_queue[0].drain && pending_replies.size() != 0) ||
             (!(accepted_count >= QUIET_FIRST && accepted_count < QUIET_LAST) &&
              $urandom_range(99) < IDLE_PERCENT)) begin
            start <= 1'b0;
         end else begin
            next_req = request_queue.pop_front();
            start <= 1'b1;
            req_mode <= next_req.mode;
            req_ip_key <= next_req.ip;
            req_mac_value <= next_req.mac;
         end
      end
   end

   // Receiver: checks responses and records accepted requests on the rising edge.
   always @(posedge clock) begin : check_replies
      arp_reply_type want;
      req_taken = !reset && start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("response with no request outstanding", rsp_mac_result, '0);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", 48'(rsp_found), 48'(want.found));
               if (rsp_mac_result !== want.mac)
                  report_mismatch("mac_result", rsp_mac_result, want.mac);
               if (rsp_evicted !== want.evicted)
                  report_mismatch("evicted", 48'(rsp_evicted), 48'(want.evicted));
            end
         end
         if (req_taken) begin
            pending_replies.push_back(arp_cache_access(req_mode, req_ip_key, req_mac_value));
            accepted_count++;
         end
         if (req_taken || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
               $display("tb_arp_address_cache failed");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      logic [31:0] key_pool[$];
      logic [63:0] wide_mac;
      logic [31:0] key;
      int pool_size;
      int total_requests;

      // Directed part: empty table, extreme keys and values, update, fill and eviction.
      add_request(MODE_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
      add_request(MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0);
      add_request(MODE_INSERT, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
      add_request(MODE_INSERT, 32'hFFFF_FFFF, 48'h0, 1'b0);
      add_request(MODE_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
      add_request(MODE_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
      add_request(MODE_INSERT, 32'h0000_0000, 48'hA5A5_5A5A_0F0F, 1'b0);
      add_request(MODE_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
      add_request(MODE_LOOKUP, 32'h1234_5678, 48'h0, 1'b0);
      for (int i = 2; i < CACHE_SLOTS; i++)
         add_request(MODE_INSERT, 32'h0A00_0000 + i, 48'h0200_0000_0000 + 48'(i * 257), 1'b0);
      // The table is full now, so the next new key replaces the oldest entry.
      add_request(MODE_INSERT, 32'hC0A8_0101, 48'h0011_2233_4455, 1'b0);
      add_request(MODE_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
      add_request(MODE_INSERT, 32'hFFFF_FFFF, 48'h8000_0000_0001, 1'b0);
      add_request(MODE_INSERT, 32'hC0A8_0102, 48'h0066_7788_99AA, 1'b0);
      add_request(MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0);

      // Random part: keys mostly from a small pool so hits, updates and evictions are common.
      for (int p = 0; p < PHASES; p++) begin
         key_pool.delete();
         pool_size = (p == 0) ? 2 : (p == 1) ? 64 : $urandom_range(4, 48);
         for (int k = 0; k < pool_size; k++) begin
            case ($urandom_range(9))
               0: key_pool.push_back(32'h0000_0000);
               1: key_pool.push_back(32'hFFFF_FFFF);
               default: key_pool.push_back($urandom);
            endcase
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if ($urandom_range(99) < 80)
               key = key_pool[$urandom_range(pool_size - 1)];
            else
               key = $urandom;
            wide_mac = {$urandom, $urandom};
            // Each phase opens with the sender waiting for all responses.
            add_request(logic'($urandom_range(1)), key, wide_mac[47:0], n == 0);
         end
      end
      total_requests = request_queue.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests || pending_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_arp_address_cache passed");
      end else begin
         $display("tb_arp_address_cache failed");
      end
      $finish;
   end

endmodule
